FILE: hdl/sqgu_pkg.sv
// Shared constants, types and tables of the single-qubit gate unit.
package sqgu_pkg;

  // Field widths
  localparam int AmpW         = 16;
  localparam int AngleW       = 16;
  localparam int CordicStages = 16;
  localparam int NumStages    = (CordicStages > 32) ? 32 : CordicStages;

  // Internal fixed-point widths
  localparam int TurnW = 32;               // binary angle, full turn = 2^32
  localparam int CordW = 34;               // Q2.30 vectors with headroom
  localparam int CoefW = 32;               // cos / sin / 1/sqrt2 coefficients
  localparam int FracW = 30;
  localparam int ProdW = AmpW + 1 + CoefW;
  localparam int WideW = ProdW + 2;

  // Gate codes
  localparam logic [2:0] GateX     = 3'd0;
  localparam logic [2:0] GateY     = 3'd1;
  localparam logic [2:0] GateZ     = 3'd2;
  localparam logic [2:0] GateH     = 3'd3;
  localparam logic [2:0] GatePhase = 3'd4;
  localparam logic [2:0] GateT     = 3'd5;

  // Fixed-point constants
  localparam logic signed [CoefW-1:0] InvSqrt2   = 32'sd759250125;
  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam logic [TurnW-1:0]        TurnEighth = 32'h2000_0000;
  localparam logic [TurnW-1:0]        TurnHalf   = 32'h8000_0000;

  // Amplitude pair plus gate code, carried down the pipeline
  typedef struct packed {
    logic [2:0]             mode;
    logic signed [AmpW-1:0] ar;
    logic signed [AmpW-1:0] ai;
    logic signed [AmpW-1:0] br;
    logic signed [AmpW-1:0] bi;
  } amp_t;

  // CORDIC stage contents
  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [CordW-1:0] z;
    logic                    flip;
    amp_t                    amp;
  } cord_t;

  // Product stage contents
  typedef struct packed {
    logic signed [ProdW-1:0] p0;
    logic signed [ProdW-1:0] p1;
    logic signed [ProdW-1:0] p2;
    logic signed [ProdW-1:0] p3;
    amp_t                    amp;
  } prod_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [TurnW-1:0] atan_turn(input logic [4:0] idx);
    logic [TurnW-1:0] v;
    unique case (idx)
      5'd0:  v = 32'h2000_0000;
      5'd1:  v = 32'h12E4_051E;
      5'd2:  v = 32'h09FB_385B;
      5'd3:  v = 32'h0511_11D4;
      5'd4:  v = 32'h028B_0D43;
      5'd5:  v = 32'h0145_D7E1;
      5'd6:  v = 32'h00A2_F61E;
      5'd7:  v = 32'h0051_7C55;
      5'd8:  v = 32'h0028_BE53;
      5'd9:  v = 32'h0014_5F2F;
      5'd10: v = 32'h000A_2F98;
      5'd11: v = 32'h0005_17CC;
      5'd12: v = 32'h0002_8BE6;
      5'd13: v = 32'h0001_45F3;
      5'd14: v = 32'h0000_A2FA;
      5'd15: v = 32'h0000_517D;
      5'd16: v = 32'h0000_28BE;
      5'd17: v = 32'h0000_145F;
      5'd18: v = 32'h0000_0A30;
      5'd19: v = 32'h0000_0518;
      5'd20: v = 32'h0000_028C;
      5'd21: v = 32'h0000_0146;
      5'd22: v = 32'h0000_00A3;
      5'd23: v = 32'h0000_0051;
      5'd24: v = 32'h0000_0029;
      5'd25: v = 32'h0000_0014;
      5'd26: v = 32'h0000_000A;
      5'd27: v = 32'h0000_0005;
      5'd28: v = 32'h0000_0003;
      5'd29: v = 32'h0000_0001;
      5'd30: v = 32'h0000_0001;
      5'd31: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/sqgu_req_if.sv
// Request channel: gate code, amplitude pair and phase angle.
interface sqgu_req_if import sqgu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [2:0]             mode;
  logic signed [AmpW-1:0] alpha_re;
  logic signed [AmpW-1:0] alpha_im;
  logic signed [AmpW-1:0] beta_re;
  logic signed [AmpW-1:0] beta_im;
  logic [AngleW-1:0]      phase_angle;

  modport source (
    output valid, mode, alpha_re, alpha_im, beta_re, beta_im, phase_angle,
    input  ready
  );
  modport sink (
    input  valid, mode, alpha_re, alpha_im, beta_re, beta_im, phase_angle,
    output ready
  );
endinterface

FILE: hdl/sqgu_res_if.sv
// Result channel: new amplitude pair.
interface sqgu_res_if import sqgu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [AmpW-1:0] new_alpha_re;
  logic signed [AmpW-1:0] new_alpha_im;
  logic signed [AmpW-1:0] new_beta_re;
  logic signed [AmpW-1:0] new_beta_im;

  modport source (
    output valid, new_alpha_re, new_alpha_im, new_beta_re, new_beta_im,
    input  ready
  );
  modport sink (
    input  valid, new_alpha_re, new_alpha_im, new_beta_re, new_beta_im,
    output ready
  );
endinterface

FILE: hdl/sqgu_cordic.sv
// Angle reduction and pipelined rotation-mode CORDIC, one iteration per stage.
module sqgu_cordic import sqgu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  amp_t              amp_i,
  input  logic [AngleW-1:0] phase_i,
  output logic              valid_o,
  input  logic              ready_i,
  output cord_t             data_o
);

  logic [TurnW-1:0] turn;
  logic [TurnW-1:0] turn_red;
  logic             flip;
  cord_t            first;

  cord_t                st_q [NumStages];
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] rdy;

  // Pick the angle and fold quadrants 1 and 2 onto 3 and 0
  always_comb begin
    if (amp_i.mode == GateT) begin
      turn = TurnEighth;
    end else begin
      turn = TurnW'(phase_i) << (TurnW - AngleW);
    end
    flip     = (turn[TurnW-1:TurnW-2] == 2'b01) || (turn[TurnW-1:TurnW-2] == 2'b10);
    turn_red = flip ? (turn ^ TurnHalf) : turn;
    first.x    = CordicGain;
    first.y    = '0;
    first.z    = CordW'($signed(turn_red));
    first.flip = flip;
    first.amp  = amp_i;
  end

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    cord_t                   cin;
    cord_t                   cout;
    logic                    vin;
    logic                    rnext;
    logic signed [CordW-1:0] dx;
    logic signed [CordW-1:0] dy;
    logic signed [CordW-1:0] at;

    if (k == 0) begin : g_head
      assign cin = first;
      assign vin = valid_i;
    end else begin : g_body
      assign cin = st_q[k-1];
      assign vin = v_q[k-1];
    end

    if (k == NumStages - 1) begin : g_tail
      assign rnext = ready_i;
    end else begin : g_mid
      assign rnext = rdy[k+1];
    end

    // Stage can load when empty or when its content moves on
    assign rdy[k] = ~v_q[k] | rnext;

    // One micro-rotation
    always_comb begin
      dx   = cin.y >>> k;
      dy   = cin.x >>> k;
      at   = CordW'(atan_turn(5'(k)));
      cout = cin;
      if (!cin.z[CordW-1]) begin
        cout.x = cin.x - dx;
        cout.y = cin.y + dy;
        cout.z = cin.z - at;
      end else begin
        cout.x = cin.x + dx;
        cout.y = cin.y - dy;
        cout.z = cin.z + at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && vin) begin
        st_q[k] <= cout;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NumStages-1];
  assign data_o  = st_q[NumStages-1];

endmodule

FILE: hdl/sqgu_mult.sv
// Operand selection and the four registered products.
module sqgu_mult import sqgu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  cord_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output prod_t data_o
);

  logic signed [CordW-1:0] cx;
  logic signed [CordW-1:0] sy;
  logic signed [CoefW-1:0] c;
  logic signed [CoefW-1:0] s;
  logic signed [AmpW:0]    a0, a1, a2, a3;
  logic signed [CoefW-1:0] b0, b1, b2, b3;
  prod_t                   prod_d;
  prod_t                   prod_q;
  logic                    v_q;

  // Undo the half-turn fold on cos and sin
  always_comb begin
    cx = data_i.flip ? -data_i.x : data_i.x;
    sy = data_i.flip ? -data_i.y : data_i.y;
    c  = $signed(cx[CoefW-1:0]);
    s  = $signed(sy[CoefW-1:0]);
  end

  // Hadamard scales sums and differences, phase gates rotate beta
  always_comb begin
    if (data_i.amp.mode == GateH) begin
      a0 = (AmpW+1)'(data_i.amp.ar) + (AmpW+1)'(data_i.amp.br);
      a1 = (AmpW+1)'(data_i.amp.ai) + (AmpW+1)'(data_i.amp.bi);
      a2 = (AmpW+1)'(data_i.amp.ar) - (AmpW+1)'(data_i.amp.br);
      a3 = (AmpW+1)'(data_i.amp.ai) - (AmpW+1)'(data_i.amp.bi);
      b0 = InvSqrt2;
      b1 = InvSqrt2;
      b2 = InvSqrt2;
      b3 = InvSqrt2;
    end else begin
      a0 = (AmpW+1)'(data_i.amp.br);
      a1 = (AmpW+1)'(data_i.amp.bi);
      a2 = (AmpW+1)'(data_i.amp.br);
      a3 = (AmpW+1)'(data_i.amp.bi);
      b0 = c;
      b1 = s;
      b2 = s;
      b3 = c;
    end
    prod_d.p0  = a0 * b0;
    prod_d.p1  = a1 * b1;
    prod_d.p2  = a2 * b2;
    prod_d.p3  = a3 * b3;
    prod_d.amp = data_i.amp;
  end

  assign ready_o = ~v_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = prod_q;

endmodule

FILE: hdl/sqgu_final.sv
// Gate select, rounding, saturation and the output register.
module sqgu_final import sqgu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  prod_t        data_i,
  sqgu_res_if.source   res_o
);

  localparam logic signed [WideW-1:0] AmpMax = WideW'((64'sd1 <<< (AmpW - 1)) - 1);
  localparam logic signed [WideW-1:0] AmpMin = -(WideW'(64'sd1 <<< (AmpW - 1)));
  localparam logic signed [WideW-1:0] Half   = WideW'(64'sd1 <<< (FracW - 1));

  logic signed [WideW-1:0] ar, ai, br, bi;
  logic signed [WideW-1:0] r0, r1, r2, r3;
  logic signed [AmpW-1:0]  na_re_d, na_im_d, nb_re_d, nb_im_d;
  logic signed [AmpW-1:0]  na_re_q, na_im_q, nb_re_q, nb_im_q;
  logic                    v_q;

  // Round to nearest, ties up
  function automatic logic signed [WideW-1:0] rnd(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] t;
    t = v + Half;
    return t >>> FracW;
  endfunction

  function automatic logic signed [AmpW-1:0] sat(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] t;
    if (v > AmpMax) begin
      t = AmpMax;
    end else if (v < AmpMin) begin
      t = AmpMin;
    end else begin
      t = v;
    end
    return $signed(t[AmpW-1:0]);
  endfunction

  // Per-gate result before saturation
  always_comb begin
    ar = WideW'(data_i.amp.ar);
    ai = WideW'(data_i.amp.ai);
    br = WideW'(data_i.amp.br);
    bi = WideW'(data_i.amp.bi);
    r0 = ar;
    r1 = ai;
    r2 = br;
    r3 = bi;
    unique case (data_i.amp.mode)
      GateX: begin
        r0 = br;
        r1 = bi;
        r2 = ar;
        r3 = ai;
      end
      GateY: begin
        r0 = bi;
        r1 = -br;
        r2 = -ai;
        r3 = ar;
      end
      GateZ: begin
        r2 = -br;
        r3 = -bi;
      end
      GateH: begin
        r0 = rnd(WideW'(data_i.p0));
        r1 = rnd(WideW'(data_i.p1));
        r2 = rnd(WideW'(data_i.p2));
        r3 = rnd(WideW'(data_i.p3));
      end
      GatePhase, GateT: begin
        r2 = rnd(WideW'(data_i.p0) - WideW'(data_i.p1));
        r3 = rnd(WideW'(data_i.p2) + WideW'(data_i.p3));
      end
      default: begin
        r0 = ar;
      end
    endcase
    na_re_d = sat(r0);
    na_im_d = sat(r1);
    nb_re_d = sat(r2);
    nb_im_d = sat(r3);
  end

  assign ready_o = ~v_q | res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      na_re_q <= na_re_d;
      na_im_q <= na_im_d;
      nb_re_q <= nb_re_d;
      nb_im_q <= nb_im_d;
    end
  end

  assign res_o.valid        = v_q;
  assign res_o.new_alpha_re = na_re_q;
  assign res_o.new_alpha_im = na_im_q;
  assign res_o.new_beta_re  = nb_re_q;
  assign res_o.new_beta_im  = nb_im_q;

`ifndef SYNTHESIS
  // X swaps the two amplitudes
  a_swap_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o && data_i.amp.mode == GateX) |=>
    (res_o.new_alpha_re == $past(data_i.amp.br) && res_o.new_beta_im == $past(data_i.amp.ai)))
    else $error("X gate did not swap amplitudes");

  // Hadamard of equal amplitudes leaves beta at zero
  a_had_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o && data_i.amp.mode == GateH &&
     data_i.amp.ar == data_i.amp.br && data_i.amp.ai == data_i.amp.bi) |=>
    (res_o.new_beta_re == '0 && res_o.new_beta_im == '0))
    else $error("Hadamard difference of equal amplitudes not zero");

  // Phase gates never touch alpha
  a_phase_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o && (data_i.amp.mode == GatePhase || data_i.amp.mode == GateT)) |=>
    (res_o.new_alpha_re == $past(data_i.amp.ar) && res_o.new_alpha_im == $past(data_i.amp.ai)))
    else $error("phase gate changed alpha");
`endif

endmodule

FILE: hdl/single_qubit_gate_unit_core.sv
// Path: the CORDIC stages, then the product register, then the output register.
// Throughput: one request per cycle while res_o.ready is high; every stage holds its own
// valid bit and loads whenever it is empty or its content moves on, so bubbles collapse.
// The CORDIC pipeline, one iteration per stage, sets the depth.
// Reset (rst_ni, async, active low) clears only the valid bits; data is not reset.
module single_qubit_gate_unit_core import sqgu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sqgu_req_if.sink   req_i,
  sqgu_res_if.source res_o
);

  amp_t  amp;
  logic  cord_valid;
  logic  cord_ready;
  cord_t cord_data;
  logic  prod_valid;
  logic  prod_ready;
  prod_t prod_data;

  // Gather the request payload
  assign amp.mode = req_i.mode;
  assign amp.ar   = req_i.alpha_re;
  assign amp.ai   = req_i.alpha_im;
  assign amp.br   = req_i.beta_re;
  assign amp.bi   = req_i.beta_im;

  sqgu_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .amp_i   (amp),
    .phase_i (req_i.phase_angle),
    .valid_o (cord_valid),
    .ready_i (cord_ready),
    .data_o  (cord_data)
  );

  sqgu_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cord_valid),
    .ready_o (cord_ready),
    .data_i  (cord_data),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .data_o  (prod_data)
  );

  sqgu_final u_final (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .data_i  (prod_data),
    .res_o   (res_o)
  );

endmodule
